// ----- sv/scsa_pkg.sv -----
// Shared types, constants and class tables of the size-class slab allocator.
package scsa_pkg;

    localparam int PAGE_COUNT   = 16;
    localparam int ADDR_PAGES   = 16;
    localparam int USABLE_PAGES = (PAGE_COUNT < ADDR_PAGES) ? PAGE_COUNT : ADDR_PAGES;
    localparam int PAGE_W       = $clog2(ADDR_PAGES);
    localparam int CLASS_COUNT  = 45;
    localparam int CLASS_W      = 6;
    localparam int CLS_DEPTH    = 64;
    localparam int MAX_SMALL    = 32736;
    localparam int BLK_DEPTH    = 65536;
    localparam int BLK_W        = 14;
    localparam int DIV_STEPS    = 16;

    localparam logic [4:0]  NO_PAGE  = 5'd31;
    localparam logic [12:0] NO_BLOCK = 13'h1FFF;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_BIG    = 3'd2,
        ST_NOPAGE = 3'd3,
        ST_INVAL  = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_FCLS, OP_HT, OP_POP, OP_FRESH, OP_INIT,
        OP_PF, OP_LINKN, OP_SERVE, OP_TAKE, OP_UNRD, OP_UNQ, OP_UNN, OP_PB,
        OP_PBLINK, OP_MUL, OP_DIVI, OP_DIV, OP_FRD, OP_FWR, OP_SPARE, OP_OUT
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t st;
    } ctl_t;

    typedef struct packed {
        logic is_free;
        logic zero;
        logic too_large;
        logic need_page;
        logic has_spare;
        logic has_fresh;
        logic full;
        logic used_zero;
        logic bad;
        logic div_done;
        logic rem_nz;
        logic not_taken;
        logic clr_done;
    } sts_t;

    typedef struct packed {
        logic [14:0] bytes;
        logic [11:0] total;
        logic [15:0] base;
    } cls_info_t;

    // Block size, blocks per page and first block offset of each class.
    function automatic cls_info_t cls_info(input logic [5:0] c);
        cls_info_t r;
        begin
            case (c)
                6'd0:  r = '{15'd16,    12'd4092, 16'd64};
                6'd4:  r = '{15'd32,    12'd2046, 16'd64};
                6'd6:  r = '{15'd48,    12'd1364, 16'd64};
                6'd8:  r = '{15'd64,    12'd1023, 16'd64};
                6'd9:  r = '{15'd80,    12'd818,  16'd96};
                6'd10: r = '{15'd96,    12'd682,  16'd64};
                6'd11: r = '{15'd112,   12'd584,  16'd128};
                6'd12: r = '{15'd128,   12'd511,  16'd128};
                6'd13: r = '{15'd160,   12'd409,  16'd96};
                6'd14: r = '{15'd192,   12'd341,  16'd64};
                6'd15: r = '{15'd224,   12'd292,  16'd128};
                6'd16: r = '{15'd256,   12'd255,  16'd256};
                6'd17: r = '{15'd320,   12'd204,  16'd256};
                6'd18: r = '{15'd384,   12'd170,  16'd256};
                6'd19: r = '{15'd448,   12'd146,  16'd128};
                6'd20: r = '{15'd512,   12'd127,  16'd512};
                6'd21: r = '{15'd640,   12'd102,  16'd256};
                6'd22: r = '{15'd768,   12'd85,   16'd256};
                6'd23: r = '{15'd896,   12'd73,   16'd128};
                6'd24: r = '{15'd1024,  12'd63,   16'd1024};
                6'd25: r = '{15'd1280,  12'd51,   16'd256};
                6'd26: r = '{15'd1536,  12'd42,   16'd1024};
                6'd27: r = '{15'd1792,  12'd36,   16'd1024};
                6'd28: r = '{15'd2048,  12'd31,   16'd2048};
                6'd29: r = '{15'd2560,  12'd25,   16'd1536};
                6'd30: r = '{15'd3072,  12'd21,   16'd1024};
                6'd31: r = '{15'd3584,  12'd18,   16'd1024};
                6'd32: r = '{15'd4096,  12'd15,   16'd4096};
                6'd33: r = '{15'd5120,  12'd12,   16'd4096};
                6'd34: r = '{15'd6144,  12'd10,   16'd4096};
                6'd35: r = '{15'd7168,  12'd9,    16'd1024};
                6'd36: r = '{15'd8192,  12'd7,    16'd8192};
                6'd37: r = '{15'd10240, 12'd6,    16'd4096};
                6'd38: r = '{15'd12288, 12'd5,    16'd4096};
                6'd39: r = '{15'd14336, 12'd4,    16'd8192};
                6'd40: r = '{15'd16384, 12'd3,    16'd16384};
                6'd41: r = '{15'd20480, 12'd3,    16'd4096};
                6'd42: r = '{15'd24576, 12'd2,    16'd16384};
                6'd43: r = '{15'd28672, 12'd2,    16'd8192};
                6'd44: r = '{15'd32736, 12'd2,    16'd64};
                default: r = '{15'd0, 12'd0, 16'd0};
            endcase
            return r;
        end
    endfunction

    // Four classes per octave (fewer below 64 bytes) after rounding the size up to 16 bytes.
    function automatic logic [5:0] class_of(input logic [15:0] size);
        logic [15:0] s;
        logic [15:0] v;
        logic [3:0]  lg;
        logic [15:0] sh;
        logic [7:0]  r;
        begin
            s  = (size + 16'd15) & 16'hFFF0;
            v  = (s - 16'd1) | 16'd1;
            lg = '0;
            for (int i = 1; i < 16; i++) begin
                if (v[i]) lg = 4'(i);
            end
            sh = (s - 16'd1) >> (lg - 4'd2);
            r  = {2'b00, lg, 2'b00} + sh[7:0] - 8'd19;
            return r[5:0];
        end
    endfunction

endpackage

// ----- sv/size_class_slab_allocator.sv -----
// Top level of the size-class slab allocator: sequencer plus datapath.
//
// A request beat is taken at a rising edge where start is high and busy is low.
// command 0 allocates request_size bytes, command 1 frees block_address.
// Exactly one result beat follows each request: done is high for a single
// cycle with status, granted_address, granted_bytes and size_class valid.
// The receiver cannot stall; a result must be taken in its strobe cycle.
// An allocation raises done once the list relinking steps and the one-port
// block store accesses are through (a new page adds three steps, a page that
// fills adds five); zero or oversize requests answer straight after decoding
// and an allocation with no page left after the page check.
// A good free passes through the bit-serial divider that turns the byte offset
// into a block index; a bad free answers after the page check, the divide or
// the taken-bit read. Busy falls with the result strobe, so the next request
// can be taken in the cycle the result is shown: one request is in flight.
// After reset the block store's taken bits are cleared by a pass over all
// 65536 entries, one entry per cycle, with busy held high; only then is start
// taken. Reset also empties every class list, the spare page stack and the
// count of fresh pages handed out.
module size_class_slab_allocator
    import scsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [15:0] request_size,
    input  logic [19:0] block_address,
    output logic        done,
    output logic [2:0]  status,
    output logic [19:0] granted_address,
    output logic [14:0] granted_bytes,
    output logic [5:0]  size_class
);

    ctl_t ctl;
    sts_t sts;

    scsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    scsa_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .command         (command),
        .request_size    (request_size),
        .block_address   (block_address),
        .sts             (sts),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .granted_bytes   (granted_bytes),
        .size_class      (size_class)
    );

    // The result beat comes out only once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // One request gives one result beat, never two in a row.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    // Rejected sizes and bad frees report no class and no address.
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_ZERO || status == ST_BIG || status == ST_INVAL)
        |-> granted_address == 20'd0 && granted_bytes == 15'd0 && size_class == 6'd0)
        else $error("error result carries data");

    // Only a good allocation hands out an address.
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && granted_address != 20'd0 |-> status == ST_OK)
        else $error("address granted with error status");

endmodule

// ----- sv/scsa_ram.sv -----
// Generic single-port RAM with registered read data.
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

// ----- sv/scsa_ctrl.sv -----
// Sequencer of the slab allocator: steps the datapath through one request.
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy
);

    typedef enum logic [22:0] {
        S_CLR   = 23'd1 << 0,
        S_IDLE  = 23'd1 << 1,
        S_DEC   = 23'd1 << 2,
        S_HEAD  = 23'd1 << 3,
        S_CHK   = 23'd1 << 4,
        S_INIT  = 23'd1 << 5,
        S_PF    = 23'd1 << 6,
        S_LINKN = 23'd1 << 7,
        S_SERVE = 23'd1 << 8,
        S_TAKE  = 23'd1 << 9,
        S_U1    = 23'd1 << 10,
        S_U2    = 23'd1 << 11,
        S_U3    = 23'd1 << 12,
        S_PB1   = 23'd1 << 13,
        S_PB2   = 23'd1 << 14,
        S_MUL   = 23'd1 << 15,
        S_FCHK  = 23'd1 << 16,
        S_DIV   = 23'd1 << 17,
        S_FRD   = 23'd1 << 18,
        S_FTK   = 23'd1 << 19,
        S_SPARE = 23'd1 << 20,
        S_OUT   = 23'd1 << 21,
        S_FCLS  = 23'd1 << 22
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    op_t     op;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        op         = OP_NONE;
        case (state_reg)
            S_CLR:
            begin
                op = OP_CLR;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    st_next    = ST_OK;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.is_free) state_next = S_FCLS;
                else if (sts.zero)
                begin
                    st_next    = ST_ZERO;
                    state_next = S_OUT;
                end
                else if (sts.too_large)
                begin
                    st_next    = ST_BIG;
                    state_next = S_OUT;
                end
                else state_next = S_HEAD;
            end
            S_FCLS:
            begin
                op         = OP_FCLS;
                state_next = S_FCHK;
            end
            S_HEAD:
            begin
                op         = OP_HT;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!sts.need_page) state_next = S_SERVE;
                else if (sts.has_spare)
                begin
                    op         = OP_POP;
                    state_next = S_INIT;
                end
                else if (sts.has_fresh)
                begin
                    op         = OP_FRESH;
                    state_next = S_INIT;
                end
                else
                begin
                    st_next    = ST_NOPAGE;
                    state_next = S_OUT;
                end
            end
            S_INIT:
            begin
                op         = OP_INIT;
                state_next = S_PF;
            end
            S_PF:
            begin
                op         = OP_PF;
                state_next = S_LINKN;
            end
            S_LINKN:
            begin
                op         = OP_LINKN;
                state_next = sts.is_free ? S_OUT : S_SERVE;
            end
            S_SERVE:
            begin
                op         = OP_SERVE;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                op         = OP_TAKE;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                op         = OP_MUL;
                state_next = sts.full ? S_U1 : S_OUT;
            end
            S_U1:
            begin
                op         = OP_UNRD;
                state_next = S_U2;
            end
            S_U2:
            begin
                op         = OP_UNQ;
                state_next = S_U3;
            end
            S_U3:
            begin
                op = OP_UNN;
                if (!sts.is_free) state_next = S_PB1;
                else if (sts.used_zero) state_next = S_SPARE;
                else state_next = S_PF;
            end
            S_PB1:
            begin
                op         = OP_PB;
                state_next = S_PB2;
            end
            S_PB2:
            begin
                op         = OP_PBLINK;
                state_next = S_OUT;
            end
            S_FCHK:
            begin
                if (sts.bad)
                begin
                    st_next    = ST_INVAL;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = OP_DIVI;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                op = OP_DIV;
                if (sts.div_done) state_next = S_FRD;
            end
            S_FRD:
            begin
                if (sts.rem_nz)
                begin
                    st_next    = ST_INVAL;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = OP_FRD;
                    state_next = S_FTK;
                end
            end
            S_FTK:
            begin
                if (sts.not_taken)
                begin
                    st_next    = ST_INVAL;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = OP_FWR;
                    state_next = S_U1;
                end
            end
            S_SPARE:
            begin
                op         = OP_SPARE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                op         = OP_OUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign ctl.op = op;
    assign ctl.st = st_reg;
    assign busy   = (state_reg != S_IDLE);

endmodule

// ----- sv/scsa_dpath.sv -----
// Datapath of the slab allocator: page records, class lists, block store, divider.
module scsa_dpath
    import scsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  logic        command,
    input  logic [15:0] request_size,
    input  logic [19:0] block_address,
    output sts_t        sts,
    output logic        done,
    output logic [2:0]  status,
    output logic [19:0] granted_address,
    output logic [14:0] granted_bytes,
    output logic [5:0]  size_class
);

    // Per-page records.
    logic [ADDR_PAGES-1:0] in_use_reg;
    logic [5:0]  pg_class_reg  [ADDR_PAGES];
    logic [11:0] pg_used_reg   [ADDR_PAGES];
    logic [11:0] pg_mapped_reg [ADDR_PAGES];
    logic [12:0] pg_fhead_reg  [ADDR_PAGES];
    logic [4:0]  lnext_reg     [ADDR_PAGES];
    logic [4:0]  lprev_reg     [ADDR_PAGES];
    logic [PAGE_W-1:0] spare_reg [ADDR_PAGES];
    logic [4:0]  depth_reg, fresh_reg;
    logic [CLASS_COUNT-1:0] cvalid_reg;
    logic [15:0] clr_cnt_reg;

    // Request registers.
    logic        cmd_reg, fl_reg, full_reg, uz_reg, bad_reg, done_reg;
    logic [15:0] size_reg, off_reg;
    logic [PAGE_W-1:0] p_reg;
    logic [5:0]  c_reg;
    logic [11:0] idx_reg;
    logic [4:0]  h_reg, t_reg, n_reg, q_reg;
    logic [26:0] prod_reg;
    logic [15:0] rem_reg, quo_reg;
    logic [3:0]  cnt_reg;
    logic [2:0]  status_reg;
    logic [19:0] gaddr_reg;
    logic [14:0] gbytes_reg;
    logic [5:0]  gclass_reg;

    cls_info_t   info;
    logic [16:0] trial;
    logic        ge;
    logic [15:0] rem_next;
    logic [4:0]  head_rd, tail_rd;
    logic [12:0] used_inc;

    logic                 blk_we;
    logic [15:0]          blk_addr;
    logic [BLK_W-1:0]     blk_wdata, blk_rdata;
    logic                 cls_we;
    logic [9:0]           cls_rdata;

    assign info     = cls_info(c_reg);
    assign trial    = {rem_reg, quo_reg[15]};
    assign ge       = trial >= {2'b00, info.bytes};
    assign rem_next = ge ? 16'(trial - {2'b00, info.bytes}) : trial[15:0];
    assign head_rd  = cvalid_reg[c_reg] ? cls_rdata[9:5] : NO_PAGE;
    assign tail_rd  = cvalid_reg[c_reg] ? cls_rdata[4:0] : NO_PAGE;
    assign used_inc = {1'b0, pg_used_reg[p_reg]} + 13'd1;

    always_comb
    begin
        sts.is_free   = cmd_reg;
        sts.zero      = (size_reg == 16'd0);
        sts.too_large = (size_reg > 16'(MAX_SMALL));
        sts.need_page = (h_reg == NO_PAGE) || (pg_used_reg[p_reg] >= info.total);
        sts.has_spare = (depth_reg != 5'd0);
        sts.has_fresh = (fresh_reg < 5'(USABLE_PAGES));
        sts.full      = full_reg;
        sts.used_zero = uz_reg;
        sts.bad       = bad_reg || (info.bytes == 15'd0) || (off_reg < info.base);
        sts.div_done  = (cnt_reg == 4'(DIV_STEPS - 1));
        sts.rem_nz    = (rem_reg != 16'd0) || (quo_reg[15:12] != 4'd0);
        sts.not_taken = !blk_rdata[13];
        sts.clr_done  = (clr_cnt_reg == 16'hFFFF);
    end

    always_comb
    begin
        blk_we    = 1'b0;
        blk_addr  = {p_reg, idx_reg};
        blk_wdata = '0;
        case (ctl.op)
            OP_CLR:   begin blk_we = 1'b1; blk_addr = clr_cnt_reg; end
            OP_SERVE: blk_addr = {p_reg, pg_fhead_reg[p_reg][11:0]};
            OP_FRD:   blk_addr = {p_reg, quo_reg[11:0]};
            OP_TAKE:  begin blk_we = 1'b1; blk_wdata = {1'b1, blk_rdata[12:0]}; end
            OP_FWR:   begin blk_we = 1'b1; blk_wdata = {1'b0, pg_fhead_reg[p_reg]}; end
            default:  blk_we = 1'b0;
        endcase
    end

    assign cls_we = (ctl.op == OP_OUT) && (ctl.st == ST_OK);

    scsa_ram #(.WIDTH(BLK_W), .DEPTH(BLK_DEPTH)) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .addr  (blk_addr),
        .wdata (blk_wdata),
        .rdata (blk_rdata)
    );

    scsa_ram #(.WIDTH(10), .DEPTH(CLS_DEPTH)) u_cls_ram (
        .clk   (clk),
        .we    (cls_we),
        .addr  (c_reg),
        .wdata ({h_reg, t_reg}),
        .rdata (cls_rdata)
    );

    // Control state that reset must clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            depth_reg   <= '0;
            fresh_reg   <= '0;
            cvalid_reg  <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (ctl.op == OP_OUT);
            case (ctl.op)
                OP_CLR:   clr_cnt_reg <= clr_cnt_reg + 16'd1;
                OP_POP:   depth_reg <= depth_reg - 5'd1;
                OP_FRESH: fresh_reg <= fresh_reg + 5'd1;
                OP_INIT:  in_use_reg[p_reg] <= 1'b1;
                OP_SPARE:
                begin
                    in_use_reg[p_reg] <= 1'b0;
                    depth_reg         <= depth_reg + 5'd1;
                end
                OP_OUT:   if (ctl.st == ST_OK) cvalid_reg[c_reg] <= 1'b1;
                default:  depth_reg <= depth_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                cmd_reg  <= command;
                size_reg <= request_size;
                off_reg  <= block_address[15:0];
                p_reg    <= block_address[19:16];
                c_reg    <= class_of(request_size);
            end
            OP_FCLS:
            begin
                c_reg   <= pg_class_reg[p_reg];
                bad_reg <= !in_use_reg[p_reg];
            end
            OP_HT:
            begin
                h_reg <= head_rd;
                t_reg <= tail_rd;
                p_reg <= head_rd[PAGE_W-1:0];
            end
            OP_POP:   p_reg <= spare_reg[PAGE_W'(depth_reg - 5'd1)];
            OP_FRESH: p_reg <= fresh_reg[PAGE_W-1:0];
            OP_INIT:
            begin
                pg_class_reg[p_reg]  <= c_reg;
                pg_used_reg[p_reg]   <= '0;
                pg_mapped_reg[p_reg] <= '0;
                pg_fhead_reg[p_reg]  <= NO_BLOCK;
            end
            OP_PF:
            begin
                lprev_reg[p_reg] <= NO_PAGE;
                lnext_reg[p_reg] <= h_reg;
                if (h_reg == NO_PAGE) t_reg <= {1'b0, p_reg};
                n_reg <= h_reg;
                h_reg <= {1'b0, p_reg};
            end
            OP_LINKN:
            begin
                if (n_reg != NO_PAGE) lprev_reg[n_reg[PAGE_W-1:0]] <= {1'b0, p_reg};
            end
            OP_SERVE:
            begin
                if (pg_fhead_reg[p_reg] != NO_BLOCK)
                begin
                    idx_reg <= pg_fhead_reg[p_reg][11:0];
                    fl_reg  <= 1'b1;
                end
                else
                begin
                    idx_reg              <= pg_mapped_reg[p_reg];
                    pg_mapped_reg[p_reg] <= pg_mapped_reg[p_reg] + 12'd1;
                    fl_reg               <= 1'b0;
                end
                pg_used_reg[p_reg] <= used_inc[11:0];
                full_reg           <= (used_inc >= {1'b0, info.total});
            end
            OP_TAKE:  if (fl_reg) pg_fhead_reg[p_reg] <= blk_rdata[12:0];
            OP_UNRD:
            begin
                n_reg <= lnext_reg[p_reg];
                q_reg <= lprev_reg[p_reg];
            end
            OP_UNQ:
            begin
                if (q_reg == NO_PAGE) h_reg <= n_reg;
                else lnext_reg[q_reg[PAGE_W-1:0]] <= n_reg;
            end
            OP_UNN:
            begin
                if (n_reg == NO_PAGE) t_reg <= q_reg;
                else lprev_reg[n_reg[PAGE_W-1:0]] <= q_reg;
            end
            OP_PB:
            begin
                lnext_reg[p_reg] <= NO_PAGE;
                lprev_reg[p_reg] <= t_reg;
                if (t_reg == NO_PAGE) h_reg <= {1'b0, p_reg};
                n_reg <= t_reg;
                t_reg <= {1'b0, p_reg};
            end
            OP_PBLINK:
            begin
                if (n_reg != NO_PAGE) lnext_reg[n_reg[PAGE_W-1:0]] <= {1'b0, p_reg};
            end
            OP_MUL:   prod_reg <= idx_reg * info.bytes;
            OP_DIVI:
            begin
                rem_reg <= '0;
                quo_reg <= off_reg - info.base;
                cnt_reg <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[14:0], ge};
                cnt_reg <= cnt_reg + 4'd1;
            end
            OP_FRD:
            begin
                idx_reg <= quo_reg[11:0];
                h_reg   <= head_rd;
                t_reg   <= tail_rd;
            end
            OP_FWR:
            begin
                pg_fhead_reg[p_reg] <= {1'b0, idx_reg};
                pg_used_reg[p_reg]  <= pg_used_reg[p_reg] - 12'd1;
                uz_reg              <= (pg_used_reg[p_reg] == 12'd1);
            end
            OP_SPARE: spare_reg[depth_reg[PAGE_W-1:0]] <= p_reg;
            OP_OUT:
            begin
                status_reg <= ctl.st;
                gaddr_reg  <= ((ctl.st == ST_OK) && !cmd_reg)
                              ? {p_reg, info.base + prod_reg[15:0]} : 20'd0;
                if ((ctl.st == ST_OK) || (ctl.st == ST_NOPAGE))
                begin
                    gbytes_reg <= info.bytes;
                    gclass_reg <= c_reg;
                end
                else
                begin
                    gbytes_reg <= '0;
                    gclass_reg <= '0;
                end
            end
            default: cmd_reg <= cmd_reg;
        endcase
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = gaddr_reg;
    assign granted_bytes   = gbytes_reg;
    assign size_class      = gclass_reg;

endmodule
